@@ src/mp2w_pkg.sv @@
// Package with the constants, codes and types shared by the max pooling window unit.
`timescale 1ns / 1ps

package mp2w_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int MAX_KERNEL  = 8;
   localparam int SAMPLE_BITS = 16;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int KIDX_BITS   = $clog2(MAX_KERNEL);

   localparam int INDEX_BITS  = 6;
   localparam int KERNEL_BITS = 4;
   localparam int STRIDE_BITS = 4;
   localparam int PAD_BITS    = 3;
   localparam int SIZE_BITS   = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 7;

   localparam int ORG_BITS   = INDEX_BITS + STRIDE_BITS;
   localparam int POS_BITS   = ORG_BITS + 1;
   localparam int BOUND_BITS = SIZE_BITS + 1;
   localparam int LIMIT_BITS = INDEX_BITS + 1 + STRIDE_BITS;

   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_POOL = 1'b1;

   localparam logic [CSR_ADDR_BITS-1:0] REG_KERNEL_SIZE  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_STRIDE_STEP  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PAD_AMOUNT   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PLANE_WIDTH  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PLANE_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

@@ src/max_pool_2d_window_unit.sv @@
// Top level of the max pooling window unit: sample store, window scan and result register.
//
// The unit keeps one plane of signed Q8.8 samples in a single-port synchronous store.
// Items arrive on the req_ channel and are taken when req_valid is high and req_stall
// is low. A load item writes its sample in the accepting cycle and yields no result;
// the next item can follow in the next cycle. A pool item yields one result on the
// rsp_ channel: the maximum over the kernel window, or the most negative value with
// position_invalid set when the position lies beyond the output size.
// A pool item steps a scan through the kernel window, reading the store at each position
// inside the plane; a drain state then folds in the last read and a result state loads
// the result register once it is free; req_stall is high from the accept until the
// result register is loaded, and the next item can be taken in the cycle after that.
// An invalid position or an empty kernel skips the scan and the drain state.
// The result waits in an output register while rsp_stall is high, and the unit takes
// new load items meanwhile; a further pool result waits until that register frees.
// Synchronous reset restores the register defaults and empties the result register;
// the store contents are undefined until loaded. The user must write configuration
// through the csr_ port only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps

module max_pool_2d_window_unit
   import mp2w_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [CSR_ADDR_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [INDEX_BITS-1:0]           req_row_index,
   input  logic [INDEX_BITS-1:0]           req_col_index,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_pooled_max,
   output logic                            rsp_position_invalid
);

   logic [KERNEL_BITS-1:0] kernel_size_ff;
   logic [STRIDE_BITS-1:0] stride_step_ff;
   logic [PAD_BITS-1:0]    pad_amount_ff;
   logic [SIZE_BITS-1:0]   plane_width_ff;
   logic [SIZE_BITS-1:0]   plane_height_ff;

   state_type state_ff, state_in;

   logic [ORG_BITS-1:0]  y0_ff, y0_in, x0_ff, x0_in;
   logic [KIDX_BITS-1:0] r_ff, r_in, c_ff, c_in, klast_ff, klast_in;
   logic                 inval_ff, inval_in;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic                 rsp_inval_ff, rsp_inval_in;

   logic signed [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];

   logic                   accept, accept_load, accept_pool;
   logic [STRIDE_BITS-1:0] stride_eff;
   logic [KERNEL_BITS-1:0] kern_eff;
   logic [SIZE_BITS-1:0]   h_eff, w_eff;
   logic [BOUND_BITS-1:0]  bound_h, bound_w;
   logic [LIMIT_BITS-1:0]  limit_r, limit_c;
   logic                   pos_over, kern_zero;
   logic [POS_BITS-1:0]    y_pos, x_pos;
   logic                   in_range, scan_last, load_in_store;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
   logic                   scan_active, out_free, load_result;

   assign accept      = req_valid && !req_stall;
   assign accept_load = accept && (req_action == ACT_LOAD);
   assign accept_pool = accept && (req_action == ACT_POOL);

   assign stride_eff = (stride_step_ff == '0) ? STRIDE_BITS'(1) : stride_step_ff;
   assign kern_eff   = (int'(kernel_size_ff) > MAX_KERNEL) ? KERNEL_BITS'(MAX_KERNEL)
                                                           : kernel_size_ff;
   assign kern_zero  = (kern_eff == '0);
   assign h_eff = (int'(plane_height_ff) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT)
                                                       : plane_height_ff;
   assign w_eff = (int'(plane_width_ff) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH)
                                                     : plane_width_ff;

   // Position p is at or beyond padded size/stride exactly when (p+1)*stride exceeds it.
   assign bound_h = BOUND_BITS'(plane_height_ff) + BOUND_BITS'({pad_amount_ff, 1'b0});
   assign bound_w = BOUND_BITS'(plane_width_ff) + BOUND_BITS'({pad_amount_ff, 1'b0});
   assign limit_r = (LIMIT_BITS'(req_row_index) + LIMIT_BITS'(1)) * LIMIT_BITS'(stride_eff);
   assign limit_c = (LIMIT_BITS'(req_col_index) + LIMIT_BITS'(1)) * LIMIT_BITS'(stride_eff);
   assign pos_over = (limit_r > LIMIT_BITS'(bound_h)) || (limit_c > LIMIT_BITS'(bound_w));

   assign y_pos    = POS_BITS'(y0_ff) + POS_BITS'(r_ff);
   assign x_pos    = POS_BITS'(x0_ff) + POS_BITS'(c_ff);
   assign in_range = (y_pos < POS_BITS'(h_eff)) && (x_pos < POS_BITS'(w_eff));
   assign scan_last = (r_ff == klast_ff) && (c_ff == klast_ff);

   assign load_in_store = (int'(req_row_index) < MAX_HEIGHT) &&
                          (int'(req_col_index) < MAX_WIDTH);
   assign wr_addr = ADDR_BITS'(req_row_index) * ADDR_BITS'(MAX_WIDTH)
                  + ADDR_BITS'(req_col_index);
   assign rd_addr = ADDR_BITS'(y_pos[ROW_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
                  + ADDR_BITS'(x_pos[COL_BITS-1:0]);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_pool) begin
               state_in = (pos_over || kern_zero) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      scan_active = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN: begin
            scan_active = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_RESULT: begin
            load_result = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      y0_in       = y0_ff;
      x0_in       = x0_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      klast_in    = klast_ff;
      inval_in    = inval_ff;
      best_in     = best_ff;
      rd_valid_in = scan_active && in_range;
      if (rd_valid_ff && (rd_data_ff > best_ff)) begin
         best_in = rd_data_ff;
      end
      if (accept_pool) begin
         y0_in    = ORG_BITS'(req_row_index) * ORG_BITS'(stride_eff);
         x0_in    = ORG_BITS'(req_col_index) * ORG_BITS'(stride_eff);
         r_in     = '0;
         c_in     = '0;
         klast_in = KIDX_BITS'(kern_eff - KERNEL_BITS'(1));
         inval_in = pos_over;
         best_in  = MOST_NEG;
      end
      if (scan_active) begin
         if (c_ff == klast_ff) begin
            c_in = '0;
            r_in = r_ff + KIDX_BITS'(1);
         end else begin
            c_in = c_ff + KIDX_BITS'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_inval_in = rsp_inval_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = best_ff;
         rsp_inval_in = inval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff  <= KERNEL_BITS'(2);
         stride_step_ff  <= STRIDE_BITS'(2);
         pad_amount_ff   <= '0;
         plane_width_ff  <= SIZE_BITS'(64);
         plane_height_ff <= SIZE_BITS'(64);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_KERNEL_SIZE:  kernel_size_ff  <= csr_write_data[KERNEL_BITS-1:0];
            REG_STRIDE_STEP:  stride_step_ff  <= csr_write_data[STRIDE_BITS-1:0];
            REG_PAD_AMOUNT:   pad_amount_ff   <= csr_write_data[PAD_BITS-1:0];
            REG_PLANE_WIDTH:  plane_width_ff  <= csr_write_data[SIZE_BITS-1:0];
            REG_PLANE_HEIGHT: plane_height_ff <= csr_write_data[SIZE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y0_ff        <= y0_in;
      x0_ff        <= x0_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      klast_ff     <= klast_in;
      inval_ff     <= inval_in;
      best_ff      <= best_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_inval_ff <= rsp_inval_in;
   end

   always_ff @(posedge clock) begin
      if (accept_load && load_in_store) begin
         store_mem[wr_addr] <= req_sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_in) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pooled_max       = rsp_max_ff;
   assign rsp_position_invalid = rsp_inval_ff;

endmodule

@@ src/mp2w_checker.sv @@
// Checker for the port behavior of the max pooling window unit, bound to its top level.
`timescale 1ns / 1ps

module mp2w_checker
   import mp2w_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_action,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0]   rsp_pooled_max,
   input  logic                            rsp_position_invalid
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pooled_max)
                                 && $stable(rsp_position_invalid))
      else $error("Stalled result item changed or vanished.");

   a_invalid_most_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position_invalid |-> rsp_pooled_max == MOST_NEG)
      else $error("Invalid position item without the most negative value.");

   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_action == ACT_LOAD) |=> !req_stall)
      else $error("Load item left the unit busy.");

   a_pool_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_action == ACT_POOL) |=> req_stall)
      else $error("Pool item did not hold off the next item.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item present after reset.");

endmodule

bind max_pool_2d_window_unit mp2w_checker u_checker (.*);
